[design/mlr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Shared types for the setup and stepping stages of the line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_NEXT  = 1'b1
    } func_t;

    // Mirroring applied to reach the first octant; neg_x sits in the lowest bit.
    typedef struct packed {
        logic swap;
        logic neg_y;
        logic neg_x;
    } octant_t;

endpackage
`default_nettype wire

[design/midpoint_line_rasterizer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Generates the pixels of a line segment in any octant, one point per word.
//
// Channel   Dir  tdata (low bit up)                          tuser   tlast
// s_axis    in   start_x, start_y, stop_x, stop_y            func    -
// m_axis    out  point_x, point_y                            valid   last
//
// Every input word gives exactly one output word, presented on m_axis after it
// passes an input register and an output register.
// A new word can be taken each cycle while the output is not stalled.
// Reset clears the segment state; a next word then returns an idle word.
// A stalled output holds its word while one more input word is buffered.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_unit
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // start_x, start_y, stop_x, stop_y
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // func
    input  wire logic                                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // point_x, point_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // valid_res
    output logic                                       m_axis_tuser,
    output logic                                       m_axis_tlast
);

    localparam int IN_W  = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

    logic                        advance;
    logic                        st_valid;
    func_t                       st_func;
    octant_t                     st_mode;
    logic signed [COORD_BITS:0]  st_major;
    logic signed [COORD_BITS:0]  st_minor;
    logic signed [COORD_BITS:0]  st_major_end;
    logic [COORD_BITS:0]         st_big;
    logic [COORD_BITS:0]         st_small;
    logic [COORD_BITS-1:0]       point_x;
    logic [COORD_BITS-1:0]       point_y;

    mlr_setup #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W)
    ) u_setup (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_data      (s_axis_tdata),
        .in_func      (s_axis_tuser),
        .advance      (advance),
        .st_valid     (st_valid),
        .st_func      (st_func),
        .st_mode      (st_mode),
        .st_major     (st_major),
        .st_minor     (st_minor),
        .st_major_end (st_major_end),
        .st_big       (st_big),
        .st_small     (st_small)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .st_valid     (st_valid),
        .st_func      (st_func),
        .st_mode      (st_mode),
        .st_major     (st_major),
        .st_minor     (st_minor),
        .st_major_end (st_major_end),
        .st_big       (st_big),
        .st_small     (st_small),
        .advance      (advance),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .valid_res    (m_axis_tuser),
        .point_x      (point_x),
        .point_y      (point_y),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({point_y, point_x});

endmodule
`default_nettype wire

[design/mlr_setup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer setup stage
// Input register; folds a new segment into the first octant on the way in.
// ----------------------------------------------------------------------------
module mlr_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int IN_W       = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [IN_W-1:0]       in_data,
    input  wire logic                  in_func,
    input  wire logic                  advance,
    output logic                       st_valid,
    output func_t                      st_func,
    output octant_t                    st_mode,
    output logic signed [COORD_BITS:0] st_major,
    output logic signed [COORD_BITS:0] st_minor,
    output logic signed [COORD_BITS:0] st_major_end,
    output logic [COORD_BITS:0]        st_big,
    output logic [COORD_BITS:0]        st_small
);

    localparam int CB = COORD_BITS;

    logic                 valid_reg;
    logic                 valid_next;
    func_t                func_reg;
    octant_t              mode_reg;
    octant_t              mode_c;
    logic signed [CB:0]   major_reg;
    logic signed [CB:0]   minor_reg;
    logic signed [CB:0]   end_reg;
    logic [CB:0]          big_reg;
    logic [CB:0]          small_reg;
    logic signed [CB:0]   x0;
    logic signed [CB:0]   y0;
    logic signed [CB:0]   x1;
    logic signed [CB:0]   y1;
    logic signed [CB:0]   dx_f;
    logic signed [CB:0]   dx_r;
    logic signed [CB:0]   dy_f;
    logic signed [CB:0]   dy_r;
    logic [CB:0]          adx;
    logic [CB:0]          ady;
    logic signed [CB:0]   x0m;
    logic signed [CB:0]   y0m;
    logic signed [CB:0]   x1m;
    logic signed [CB:0]   y1m;
    logic                 accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        x0   = {in_data[CB-1], in_data[CB-1:0]};
        y0   = {in_data[2*CB-1], in_data[2*CB-1:CB]};
        x1   = {in_data[3*CB-1], in_data[3*CB-1:2*CB]};
        y1   = {in_data[4*CB-1], in_data[4*CB-1:3*CB]};
        dx_f = x1 - x0;
        dx_r = x0 - x1;
        dy_f = y1 - y0;
        dy_r = y0 - y1;
        mode_c.neg_x = dx_f[CB];
        mode_c.neg_y = dy_f[CB];
        adx  = mode_c.neg_x ? dx_r : dx_f;
        ady  = mode_c.neg_y ? dy_r : dy_f;
        mode_c.swap  = (adx <= ady);
        x0m  = mode_c.neg_x ? ((CB+1)'(0) - x0) : x0;
        x1m  = mode_c.neg_x ? ((CB+1)'(0) - x1) : x1;
        y0m  = mode_c.neg_y ? ((CB+1)'(0) - y0) : y0;
        y1m  = mode_c.neg_y ? ((CB+1)'(0) - y1) : y1;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(in_func);
            mode_reg <= mode_c;
            if (mode_c.swap)
            begin
                major_reg <= y0m;
                minor_reg <= x0m;
                end_reg   <= y1m;
                big_reg   <= ady;
                small_reg <= adx;
            end
            else
            begin
                major_reg <= x0m;
                minor_reg <= y0m;
                end_reg   <= x1m;
                big_reg   <= adx;
                small_reg <= ady;
            end
        end
    end

    assign st_valid     = valid_reg;
    assign st_func      = func_reg;
    assign st_mode      = mode_reg;
    assign st_major     = major_reg;
    assign st_minor     = minor_reg;
    assign st_major_end = end_reg;
    assign st_big       = big_reg;
    assign st_small     = small_reg;

endmodule
`default_nettype wire

[design/mlr_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer stepping stage
// Holds the segment state, loads a start or steps once, and registers the point.
// ----------------------------------------------------------------------------
module mlr_step
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    st_valid,
    input  wire func_t                   st_func,
    input  wire octant_t                 st_mode,
    input  wire logic signed [COORD_BITS:0] st_major,
    input  wire logic signed [COORD_BITS:0] st_minor,
    input  wire logic signed [COORD_BITS:0] st_major_end,
    input  wire logic [COORD_BITS:0]     st_big,
    input  wire logic [COORD_BITS:0]     st_small,
    output logic                         advance,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         valid_res,
    output logic [COORD_BITS-1:0]        point_x,
    output logic [COORD_BITS-1:0]        point_y,
    output logic                         last
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 4;
    localparam int IW = COORD_BITS + 3;

    logic                 active_reg;
    logic                 active_next;
    logic signed [CB:0]   major_pos_reg;
    logic signed [CB:0]   major_pos_next;
    logic signed [CB:0]   minor_pos_reg;
    logic signed [CB:0]   minor_pos_next;
    logic signed [CB:0]   major_end_reg;
    logic signed [CB:0]   major_end_next;
    logic signed [DW-1:0] decision_reg;
    logic signed [DW-1:0] decision_next;
    logic signed [IW-1:0] inc_straight_reg;
    logic signed [IW-1:0] inc_straight_next;
    logic signed [IW-1:0] inc_diagonal_reg;
    logic signed [IW-1:0] inc_diagonal_next;
    octant_t              mode_reg;
    octant_t              mode_next;
    logic [CB:0]          span_diff;
    logic signed [CB:0]   u_c;
    logic signed [CB:0]   v_c;
    logic signed [CB:0]   x_c;
    logic signed [CB:0]   y_c;
    logic                 emit_c;
    logic                 load;
    logic                 out_valid_reg;
    logic                 valid_res_reg;
    logic                 valid_res_next;
    logic [CB-1:0]        point_x_reg;
    logic [CB-1:0]        point_x_next;
    logic [CB-1:0]        point_y_reg;
    logic [CB-1:0]        point_y_next;
    logic                 last_reg;
    logic                 last_next;

    assign advance = !out_valid_reg || out_ready;
    assign load    = advance && st_valid;

    always_comb
    begin
        active_next       = active_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        mode_next         = mode_reg;
        emit_c            = 1'b0;
        span_diff         = st_big - st_small;
        case (st_func)
            FUNC_START:
            begin
                mode_next         = st_mode;
                major_pos_next    = st_major;
                minor_pos_next    = st_minor;
                major_end_next    = st_major_end;
                decision_next     = $signed({3'b000, st_big}) - $signed({2'b00, st_small, 1'b0});
                inc_straight_next = IW'(0) - $signed({1'b0, st_small, 1'b0});
                inc_diagonal_next = $signed({1'b0, span_diff, 1'b0});
                active_next       = (st_major != st_major_end);
                emit_c            = 1'b1;
            end
            default:
            begin
                if (active_reg)
                begin
                    if (decision_reg[DW-1])
                    begin
                        minor_pos_next = minor_pos_reg + (CB+1)'(1);
                        decision_next  = decision_reg
                                       + {inc_diagonal_reg[IW-1], inc_diagonal_reg};
                    end
                    else
                    begin
                        decision_next  = decision_reg
                                       + {inc_straight_reg[IW-1], inc_straight_reg};
                    end
                    major_pos_next = major_pos_reg + (CB+1)'(1);
                    active_next    = (major_pos_next != major_end_reg);
                    emit_c         = 1'b1;
                end
            end
        endcase

        u_c = mode_next.swap ? minor_pos_next : major_pos_next;
        v_c = mode_next.swap ? major_pos_next : minor_pos_next;
        x_c = mode_next.neg_x ? ((CB+1)'(0) - u_c) : u_c;
        y_c = mode_next.neg_y ? ((CB+1)'(0) - v_c) : v_c;

        valid_res_next = emit_c;
        point_x_next   = emit_c ? x_c[CB-1:0] : '0;
        point_y_next   = emit_c ? y_c[CB-1:0] : '0;
        last_next      = emit_c && !active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            major_pos_reg    <= '0;
            minor_pos_reg    <= '0;
            major_end_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            mode_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                active_reg       <= active_next;
                major_pos_reg    <= major_pos_next;
                minor_pos_reg    <= minor_pos_next;
                major_end_reg    <= major_end_next;
                decision_reg     <= decision_next;
                inc_straight_reg <= inc_straight_next;
                inc_diagonal_reg <= inc_diagonal_next;
                mode_reg         <= mode_next;
            end
            if (advance)
            begin
                out_valid_reg <= st_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            valid_res_reg <= valid_res_next;
            point_x_reg   <= point_x_next;
            point_y_reg   <= point_y_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_next) |=> !active_reg)
        else $error("segment still active after its last point");

    a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_res_reg) |->
            (point_x_reg == '0 && point_y_reg == '0 && !last_reg))
        else $error("idle word carries a nonzero point");

    a_major_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (load && st_func == FUNC_NEXT && active_reg) |=>
            (major_pos_reg == $past(major_pos_reg) + (CB+1)'(1)))
        else $error("major axis did not advance by one");

    a_active_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(load && st_func == FUNC_START))
        else $error("segment became active without a start word");
`endif

endmodule
`default_nettype wire

[bench/midpoint_line_rasterizer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer testbench
// Drives segment starts and point requests into the rasterizer with random
// gaps on both sides and one long output stall. Every returned word is checked
// field by field against its typed point or a cycle-free line-stepping model.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_unit_test;
    import mlr_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int RANDOM_WORDS = 1000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic        valid;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } point_t;

    typedef struct {
        func_t       func;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        bit          typed;
        point_t      want;
    } stim_row_t;

    localparam point_t IDLE_POINT = '0;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    point_t pending_points[$];
    int     words_in = 0;
    int     mismatches = 0;
    bit     calm = 1'b0;
    bit     held_off = 1'b0;

    bit      seg_active = 1'b0;
    longint  seg_major = 0;
    longint  seg_minor = 0;
    longint  seg_major_end = 0;
    longint  seg_decision = 0;
    longint  seg_inc_straight = 0;
    longint  seg_inc_diagonal = 0;
    octant_t seg_octant = '0;

    // Rows with a typed point are the begin points, idle words and edge cases.
    stim_row_t directed_plan [24] = '{
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, IDLE_POINT},
        '{FUNC_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
          '{1'b1, 16'h0000, 16'h0000, 1'b1}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, IDLE_POINT},
        '{FUNC_START, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
          '{1'b1, 16'h8000, 16'h8000, 1'b0}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, IDLE_POINT},
        '{FUNC_START, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1,
          '{1'b1, 16'h7FFF, 16'h8000, 1'b0}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_START, 16'h0000, 16'h0000, 16'h0004, 16'h0002, 1'b1,
          '{1'b1, 16'h0000, 16'h0000, 1'b0}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_START, 16'h0000, 16'h0000, 16'hFFFD, 16'hFFFB, 1'b1,
          '{1'b1, 16'h0000, 16'h0000, 1'b0}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_START, 16'h0007, 16'h0007, 16'h0007, 16'h0008, 1'b1,
          '{1'b1, 16'h0007, 16'h0007, 1'b0}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, IDLE_POINT},
        '{FUNC_START, 16'h0005, 16'hFFFD, 16'h0001, 16'hFFFD, 1'b1,
          '{1'b1, 16'h0005, 16'hFFFD, 1'b0}},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT},
        '{FUNC_NEXT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, IDLE_POINT}
    };

    midpoint_line_rasterizer_unit #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic point_t place_point(input bit is_last);
        point_t p;
        longint u;
        longint v;
        if (seg_octant.swap)
        begin
            u = seg_minor;
            v = seg_major;
        end
        else
        begin
            u = seg_major;
            v = seg_minor;
        end
        if (seg_octant.neg_x)
            u = -u;
        if (seg_octant.neg_y)
            v = -v;
        p.valid = 1'b1;
        p.x = u[15:0];
        p.y = v[15:0];
        p.last = is_last;
        return p;
    endfunction

    function automatic point_t trace_step(input func_t func, input logic [63:0] data);
        point_t p;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint adx;
        longint ady;
        longint major_d;
        longint minor_d;
        p = IDLE_POINT;
        if (func == FUNC_START)
        begin
            x0 = longint'($signed(data[15:0]));
            y0 = longint'($signed(data[31:16]));
            x1 = longint'($signed(data[47:32]));
            y1 = longint'($signed(data[63:48]));
            adx = (x1 < x0) ? x0 - x1 : x1 - x0;
            ady = (y1 < y0) ? y0 - y1 : y1 - y0;
            seg_octant = '0;
            if (x1 < x0)
            begin
                seg_octant.neg_x = 1'b1;
                x0 = -x0;
                x1 = -x1;
            end
            if (y1 < y0)
            begin
                seg_octant.neg_y = 1'b1;
                y0 = -y0;
                y1 = -y1;
            end
            if (adx <= ady)
            begin
                seg_octant.swap = 1'b1;
                seg_major = y0;
                seg_minor = x0;
                seg_major_end = y1;
                major_d = ady;
                minor_d = adx;
            end
            else
            begin
                seg_major = x0;
                seg_minor = y0;
                seg_major_end = x1;
                major_d = adx;
                minor_d = ady;
            end
            seg_decision = major_d - 2 * minor_d;
            seg_inc_straight = -2 * minor_d;
            seg_inc_diagonal = 2 * (major_d - minor_d);
            seg_active = (seg_major != seg_major_end);
            p = place_point(!seg_active);
        end
        else if (seg_active)
        begin
            if (seg_decision < 0)
            begin
                seg_minor = seg_minor + 1;
                seg_decision = seg_decision + seg_inc_diagonal;
            end
            else
            begin
                seg_decision = seg_decision + seg_inc_straight;
            end
            seg_major = seg_major + 1;
            seg_active = (seg_major != seg_major_end);
            p = place_point(!seg_active);
        end
        return p;
    endfunction

    task automatic send_word(input func_t func, input logic [63:0] data, input bit typed,
                             input point_t want);
        point_t p;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= data;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        p = trace_step(func, data);
        pending_points = {pending_points, (typed ? want : p)};
        words_in++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm <= ~calm;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && words_in >= 300)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    initial
    begin
        point_t got;
        point_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast};
                if (pending_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: valid=%0d x=%0d y=%0d last=%0d",
                                 got.valid, $signed(got.x), $signed(got.y), got.last);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (got.valid !== want.valid || got.x !== want.x ||
                        got.y !== want.y || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("point mismatch: expected valid=%0d x=%0d y=%0d last=%0d, %s",
                                     want.valid, $signed(want.x), $signed(want.y), want.last,
                                     $sformatf("got valid=%0d x=%0d y=%0d last=%0d", got.valid,
                                               $signed(got.x), $signed(got.y), got.last));
                    end
                end
            end
        end
    end

    initial
    begin
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        longint adx;
        longint ady;
        longint steps;
        int count;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= FUNC_START;
        s_axis_tdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            send_word(directed_plan[i].func,
                      {directed_plan[i].ey, directed_plan[i].ex,
                       directed_plan[i].sy, directed_plan[i].sx},
                      directed_plan[i].typed, directed_plan[i].want);

        while (words_in < RANDOM_WORDS + 24)
        begin
            sx = 16'($urandom);
            sy = 16'($urandom);
            if ($urandom_range(0, 99) < 85)
            begin
                ex = sx + 16'($urandom_range(0, 24)) - 16'd12;
                ey = sy + 16'($urandom_range(0, 24)) - 16'd12;
            end
            else
            begin
                ex = 16'($urandom);
                ey = 16'($urandom);
            end
            adx = longint'($signed(ex)) - longint'($signed(sx));
            ady = longint'($signed(ey)) - longint'($signed(sy));
            adx = (adx < 0) ? -adx : adx;
            ady = (ady < 0) ? -ady : ady;
            steps = (adx > ady) ? adx : ady;
            if (steps <= 40 && $urandom_range(0, 9) < 8)
                count = int'(steps) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            else
                count = $urandom_range(0, 40);
            send_word(FUNC_START, {ey, ex, sy, sx}, 1'b0, IDLE_POINT);
            repeat (count)
                send_word(FUNC_NEXT, {$urandom, $urandom}, 1'b0, IDLE_POINT);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
